/* src/pcmb_pkg.sv */
// ----------------------------------------------------------------------------
// pcmb_pkg: shared types and constants of the palette colour-math blend unit
// Opcodes, register indexes, reset values and the per-channel placement record.
// ----------------------------------------------------------------------------
package pcmb_pkg;

  localparam int unsigned COLOR_W     = 15;
  localparam int unsigned CHAN_W      = 5;
  localparam int unsigned LEVEL_W     = 4;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned CFG_INDEX_W = 3;

  // Full shift is the byte position plus three, half scale plus two.
  localparam logic [1:0] SHIFT_FULL = 2'd3;
  localparam logic [1:0] SHIFT_HALF = 2'd2;

  // floor(x / 15) for x <= 465 as (x * 2185) >> 15.
  localparam logic [11:0] RECIP_15   = 12'd2185;
  localparam int unsigned RECIP_SHIFT = 15;

  localparam logic [LEVEL_W-1:0] BRIGHTNESS_RST = 4'd15;
  localparam logic [POS_W-1:0]   RED_POS_RST    = 5'd16;
  localparam logic [POS_W-1:0]   GREEN_POS_RST  = 5'd8;
  localparam logic [POS_W-1:0]   BLUE_POS_RST   = 5'd0;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_SUBTRACT   = 3'd1,
    REG_FIXED      = 3'd2,
    REG_RED_POS    = 3'd3,
    REG_GREEN_POS  = 3'd4,
    REG_BLUE_POS   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [POS_W-1:0] red;
    logic [POS_W-1:0] green;
    logic [POS_W-1:0] blue;
  } pos_cfg_t;

  typedef struct packed {
    logic main_black;
    logic sub_black;
    logic half;
    logic sub_fixed;
    logic main_hit;
    logic sub_hit;
  } pix_ctrl_t;

endpackage

/* src/palette_color_math_blend_unit.sv */
// ----------------------------------------------------------------------------
// palette_color_math_blend_unit: palette lookup with per-byte colour math
// Palette writes fill the store; pixel words look up main and sub colours,
// expand them and blend them by saturating add or subtract per byte.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  s_*     | in        | s_tvalid/s_tready  | s_tuser opcode, s_tdata fields
//  m_*     | out       | m_tvalid/m_tready  | m_tdata blended pixel
//  cfg_*   | in        | cfg_write          | cfg_index, cfg_data
//
// One word is taken every cycle while the read stage can accept it. A pixel moves
// in order: the palette read port registers both lookups, then expansion and the
// blend settle into the output register. A palette write gives no result.
// Reset clears the pipeline valids and the configuration registers; the palette is not
// cleared. A stalled result holds; the read stage still takes a word while
// it is empty or about to move into the output register.
module palette_color_math_blend_unit
  import pcmb_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
)
(
  input  logic                   clk,
  input  logic                   rst,
  // s_tdata: entry_index[7:0], color_value[22:8], main_index[30:23],
  //          sub_index[38:31], main_black[39], sub_black[40], half_mode[41]
  input  logic [47:0]            s_tdata,
  // s_tuser: opcode[0]
  input  logic [0:0]             s_tuser,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // m_tdata: pixel_out[31:0]
  output logic [WORD_W-1:0]      m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data
);

  localparam int unsigned ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // Unpack the input word
  logic [INDEX_W-1:0] entry_index;
  logic [COLOR_W-1:0] color_value;
  logic [INDEX_W-1:0] main_index;
  logic [INDEX_W-1:0] sub_index;
  logic               main_black;
  logic               sub_black;
  logic               half_mode;
  opcode_t            opcode;

  assign entry_index = s_tdata[7:0];
  assign color_value = s_tdata[22:8];
  assign main_index  = s_tdata[30:23];
  assign sub_index   = s_tdata[38:31];
  assign main_black  = s_tdata[39];
  assign sub_black   = s_tdata[40];
  assign half_mode   = s_tdata[41];
  assign opcode      = opcode_t'(s_tuser[0]);

  // Configuration registers
  logic [LEVEL_W-1:0] brightness;
  logic               subtract_mode;
  logic [WORD_W-1:0]  fixed_color;
  pos_cfg_t           pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness    <= BRIGHTNESS_RST;
      subtract_mode <= 1'b0;
      fixed_color   <= '0;
      pos.red       <= RED_POS_RST;
      pos.green     <= GREEN_POS_RST;
      pos.blue      <= BLUE_POS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BRIGHTNESS: brightness    <= cfg_data[LEVEL_W-1:0];
        REG_SUBTRACT:   subtract_mode <= cfg_data[0];
        REG_FIXED:      fixed_color   <= cfg_data;
        REG_RED_POS:    pos.red       <= cfg_data[POS_W-1:0];
        REG_GREEN_POS:  pos.green     <= cfg_data[POS_W-1:0];
        REG_BLUE_POS:   pos.blue      <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the read stage frees up when its pixel moves to the output
  logic      accept;
  logic      accept_pixel;
  logic      accept_write;
  logic      s1_valid;
  logic      out_load;
  pix_ctrl_t s1_ctrl;

  assign out_load     = s1_valid && (!m_tvalid || m_tready);
  assign s_tready     = !s1_valid || out_load;
  assign accept       = s_tvalid && s_tready;
  assign accept_pixel = accept && (opcode == OP_PIXEL);
  assign accept_write = accept && (opcode == OP_WRITE);

  // Palette store: one write port, two registered read ports
  logic [COLOR_W-1:0] palette [PALETTE_ENTRIES];
  logic [COLOR_W-1:0] main_rd;
  logic [COLOR_W-1:0] sub_rd;
  logic               entry_hit;

  assign entry_hit = {1'b0, entry_index} < 9'(PALETTE_ENTRIES);

  always_ff @(posedge clk) begin
    // Drop writes beyond the store
    if (accept_write && entry_hit) begin
      palette[entry_index[ADDR_W-1:0]] <= color_value;
    end
    if (accept_pixel) begin
      main_rd <= palette[main_index[ADDR_W-1:0]];
      sub_rd  <= palette[sub_index[ADDR_W-1:0]];
    end
  end

  // Read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_pixel) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_pixel) begin
      s1_ctrl.main_black <= main_black;
      s1_ctrl.sub_black  <= sub_black;
      s1_ctrl.half       <= half_mode;
      // Transparent sub at full intensity takes the fixed colour
      s1_ctrl.sub_fixed  <= (sub_index == '0) && !half_mode;
      s1_ctrl.main_hit   <= {1'b0, main_index} < 9'(PALETTE_ENTRIES);
      s1_ctrl.sub_hit    <= {1'b0, sub_index} < 9'(PALETTE_ENTRIES);
    end
  end

  // Expand both colours; an index beyond the store reads as black
  logic [COLOR_W-1:0] main_color;
  logic [COLOR_W-1:0] sub_color;
  logic [WORD_W-1:0]  main_exp;
  logic [WORD_W-1:0]  sub_exp;
  logic [WORD_W-1:0]  main_word;
  logic [WORD_W-1:0]  sub_word;
  logic [WORD_W-1:0]  blend_word;

  assign main_color = s1_ctrl.main_hit ? main_rd : '0;
  assign sub_color  = s1_ctrl.sub_hit  ? sub_rd  : '0;

  pcmb_expand u_main_expand (
    .color      (main_color),
    .brightness (brightness),
    .pos        (pos),
    .half       (s1_ctrl.half),
    .word       (main_exp)
  );

  pcmb_expand u_sub_expand (
    .color      (sub_color),
    .brightness (brightness),
    .pos        (pos),
    .half       (s1_ctrl.half),
    .word       (sub_exp)
  );

  // Black flags win over everything else on their side
  assign main_word = s1_ctrl.main_black ? '0 : main_exp;
  assign sub_word  = s1_ctrl.sub_black  ? '0 :
                     s1_ctrl.sub_fixed  ? fixed_color : sub_exp;

  // Saturating blend, one byte lane at a time
  always_comb begin
    logic [8:0] sum;
    logic [8:0] diff;
    for (int k = 0; k < 4; k++) begin
      sum  = {1'b0, main_word[8*k +: 8]} + {1'b0, sub_word[8*k +: 8]};
      diff = {1'b0, main_word[8*k +: 8]} - {1'b0, sub_word[8*k +: 8]};
      if (subtract_mode) begin
        // Borrow out means the result clamps at zero
        blend_word[8*k +: 8] = diff[8] ? 8'h00 : diff[7:0];
      end else begin
        blend_word[8*k +: 8] = sum[8] ? 8'hFF : sum[7:0];
      end
    end
  end

  // Output register: advance on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= blend_word;
    end
  end

`ifndef SYNTH
  // A pixel in the read stage that moves on always shows up as a result
  a_load_gives_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("pixel moved out of the read stage without a result");

  // A held pixel in the read stage is never lost
  a_read_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_load) |=> s1_valid)
    else $error("stalled pixel dropped from the read stage");

  // A palette write never fills the read stage
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept_write && !s1_valid) |=> !s1_valid)
    else $error("palette write entered the pixel pipeline");

  // Nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !s1_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

/* src/pcmb_expand.sv */
// ----------------------------------------------------------------------------
// pcmb_expand: BGR555 to 32-bit word expansion
// Scales each channel by master brightness and places it at its byte offset.
// ----------------------------------------------------------------------------
module pcmb_expand
  import pcmb_pkg::*;
(
  input  logic [COLOR_W-1:0] color,
  input  logic [LEVEL_W-1:0] brightness,
  input  pos_cfg_t           pos,
  input  logic               half,
  output logic [WORD_W-1:0]  word
);

  logic [CHAN_W-1:0] chan [3];
  logic [POS_W-1:0]  chan_pos [3];
  logic [CHAN_W-1:0] scaled [3];
  logic [37:0]       placed [3];
  logic [1:0]        extra;

  assign extra       = half ? SHIFT_HALF : SHIFT_FULL;
  assign chan[0]     = color[4:0];
  assign chan[1]     = color[9:5];
  assign chan[2]     = color[14:10];
  assign chan_pos[0] = pos.red;
  assign chan_pos[1] = pos.green;
  assign chan_pos[2] = pos.blue;

  // Full brightness gives v*15/15 = v, so one formula covers every level.
  always_comb begin
    logic [8:0]  prod;
    logic [20:0] quot;
    logic [5:0]  sh;
    for (int k = 0; k < 3; k++) begin
      prod      = {4'b0, chan[k]} * {5'b0, brightness};
      quot      = 21'(prod) * 21'(RECIP_15);
      scaled[k] = quot[RECIP_SHIFT +: CHAN_W];
      sh        = {1'b0, chan_pos[k]} + {4'b0, extra};
      placed[k] = 38'(scaled[k]) << sh;
    end
  end

  // Drop anything shifted beyond the top of the word.
  assign word = placed[0][WORD_W-1:0] | placed[1][WORD_W-1:0] | placed[2][WORD_W-1:0];

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for palette_color_math_blend_unit
// Streams palette writes and pixel words through the block under random
// back-pressure on both sides. A shadow palette and a colour-math model
// predict each blended pixel. Register settings change only between phases,
// with the block drained.
// ----------------------------------------------------------------------------
module testbench
  import pcmb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned DRAIN_GAP       = 6;    // two-stage pipe plus margin
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned GAP_PERCENT     = 36;

  // Register indexes past the last register; writes there must do nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    opcode_t           op;
    logic [INDEX_W-1:0] entry;
    logic [COLOR_W-1:0] color;
    logic [INDEX_W-1:0] main_idx;
    logic [INDEX_W-1:0] sub_idx;
    logic              main_black;
    logic              sub_black;
    logic              half;
  } blend_word_t;

  // Drive every input to a known value from time zero.
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic [47:0]            s_tdata   = '0;
  logic [0:0]             s_tuser   = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [WORD_W-1:0]      m_tdata;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]      cfg_data  = '0;

  // Shadow copy of the block's state and registers.
  logic [COLOR_W-1:0] shadow_palette [PALETTE_ENTRIES];
  logic [LEVEL_W-1:0] level_reg  = BRIGHTNESS_RST;
  logic               sub_reg    = 1'b0;
  logic [WORD_W-1:0]  fixed_reg  = '0;
  logic [POS_W-1:0]   red_reg    = RED_POS_RST;
  logic [POS_W-1:0]   green_reg  = GREEN_POS_RST;
  logic [POS_W-1:0]   blue_reg   = BLUE_POS_RST;

  blend_word_t        pending_words [$];
  logic [WORD_W-1:0]  expected_pixels [$];
  blend_word_t        bus_word;
  logic [WORD_W-1:0]  want_pixel;

  // Entries written so far, as seen when the stimulus is queued. Pixels only
  // ever look up entries from this list.
  bit                 queued_written [PALETTE_ENTRIES];
  logic [INDEX_W-1:0] written_list [$];

  bit                 quiet = 1'b0;   // no idling on either side
  int unsigned        failures = 0;
  int unsigned        stall_cycles = 0;

  palette_color_math_blend_unit #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Colour-math predictor
  // --------------------------------------------------------------------------

  // Scale a 5-bit channel by the master brightness, floor of v*I/15.
  function automatic logic [CHAN_W-1:0] dim_channel(logic [CHAN_W-1:0] v);
    int unsigned prod;
    prod = int'(v) * int'(level_reg);
    if (level_reg < 4'd15) begin
      return CHAN_W'(prod / 15);
    end
    return v;
  endfunction

  // Shift a channel into place; anything past bit 31 falls off.
  function automatic logic [WORD_W-1:0] place_channel(logic [CHAN_W-1:0] v,
                                                      logic [POS_W-1:0] pos,
                                                      logic [1:0] extra);
    logic [63:0] w;
    w = 64'(v) << (int'(pos) + int'(extra));
    return w[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] expand_color(logic [COLOR_W-1:0] c,
                                                     logic half);
    logic [1:0] extra;
    extra = half ? SHIFT_HALF : SHIFT_FULL;
    return place_channel(dim_channel(c[4:0]), red_reg, extra) |
           place_channel(dim_channel(c[9:5]), green_reg, extra) |
           place_channel(dim_channel(c[14:10]), blue_reg, extra);
  endfunction

  // Saturating add or floor-at-zero subtract, one byte lane at a time.
  function automatic logic [WORD_W-1:0] mix_bytes(logic [WORD_W-1:0] mw,
                                                  logic [WORD_W-1:0] sw);
    logic [WORD_W-1:0] out;
    logic [7:0]        a;
    logic [7:0]        b;
    logic [8:0]        sum;
    out = '0;
    for (int k = 0; k < 4; k++) begin
      a = mw[8*k +: 8];
      b = sw[8*k +: 8];
      if (sub_reg) begin
        out[8*k +: 8] = (a >= b) ? a - b : 8'h00;
      end else begin
        sum = {1'b0, a} + {1'b0, b};
        out[8*k +: 8] = sum[8] ? 8'hFF : sum[7:0];
      end
    end
    return out;
  endfunction

  function automatic logic [WORD_W-1:0] blended_pixel(blend_word_t w);
    logic [WORD_W-1:0] mw;
    logic [WORD_W-1:0] sw;
    mw = w.main_black ? '0 : expand_color(shadow_palette[w.main_idx], w.half);
    if (w.sub_black) begin
      sw = '0;
    end else if (w.sub_idx == '0 && !w.half) begin
      // Transparent sub pixel at full scale takes the fixed colour.
      sw = fixed_reg;
    end else begin
      sw = expand_color(shadow_palette[w.sub_idx], w.half);
    end
    return mix_bytes(mw, sw);
  endfunction

  // --------------------------------------------------------------------------
  // Driver, receiver, monitor and watchdog
  // --------------------------------------------------------------------------

  function automatic bit take_gap();
    return !quiet && ($urandom_range(0, 99) < GAP_PERCENT);
  endfunction

  // Hold the word until it is taken; advance to the next queued word, or
  // drop valid for a gap.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (bus_word.op == OP_WRITE) begin
          shadow_palette[bus_word.entry] = bus_word.color;
        end else begin
          expected_pixels.push_back(blended_pixel(bus_word));
        end
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 && !take_gap()) begin
          bus_word = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= bus_word.op;
          s_tdata  <= {6'b0, bus_word.half, bus_word.sub_black,
                       bus_word.main_black, bus_word.sub_idx, bus_word.main_idx,
                       bus_word.color, bus_word.entry};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side at random, independent of m_tvalid.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !take_gap();
    end
  end

  // Compare each taken pixel with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel_out: unexpected word, expected none, actual %h", m_tdata);
        failures++;
      end else begin
        want_pixel = expected_pixels.pop_front();
        if (m_tdata !== want_pixel) begin
          $error("pixel_out: expected %h, actual %h", want_pixel, m_tdata);
          failures++;
        end
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("** palette_color_math_blend_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic queue_word(blend_word_t w);
    pending_words.push_back(w);
    if (w.op == OP_WRITE && !queued_written[w.entry]) begin
      queued_written[w.entry] = 1'b1;
      written_list.push_back(w.entry);
    end
  endtask

  // Palette write; the pixel fields carry noise.
  task automatic queue_write(logic [INDEX_W-1:0] entry, logic [COLOR_W-1:0] color);
    blend_word_t w;
    w.op         = OP_WRITE;
    w.entry      = entry;
    w.color      = color;
    w.main_idx   = INDEX_W'($urandom);
    w.sub_idx    = INDEX_W'($urandom);
    w.main_black = 1'($urandom);
    w.sub_black  = 1'($urandom);
    w.half       = 1'($urandom);
    queue_word(w);
  endtask

  // Pixel; entry and colour carry noise.
  task automatic queue_pixel(logic [INDEX_W-1:0] main_idx, logic [INDEX_W-1:0] sub_idx,
                             logic main_black, logic sub_black, logic half);
    blend_word_t w;
    w.op         = OP_PIXEL;
    w.entry      = INDEX_W'($urandom);
    w.color      = COLOR_W'($urandom);
    w.main_idx   = main_idx;
    w.sub_idx    = sub_idx;
    w.main_black = main_black;
    w.sub_black  = sub_black;
    w.half       = half;
    queue_word(w);
  endtask

  function automatic logic [INDEX_W-1:0] any_written();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  task automatic queue_directed();
    // Fill the entries the directed pixels use, extremes first.
    queue_write(8'd0,   15'h7FFF);
    queue_write(8'd255, 15'h7FFF);
    queue_write(8'd1,   15'h0000);
    queue_write(8'd2,   15'h001F);
    queue_write(8'd3,   15'h03E0);
    queue_write(8'd4,   15'h7C00);
    queue_write(8'd5,   15'h5555);
    queue_write(8'd254, 15'h2AAA);
    queue_pixel(8'd255, 8'd255, 1'b0, 1'b0, 1'b0);  // saturate every colour lane
    queue_pixel(8'd1,   8'd1,   1'b0, 1'b0, 1'b0);  // all zero
    queue_pixel(8'd0,   8'd0,   1'b0, 1'b0, 1'b0);  // transparent sub, fixed colour
    queue_pixel(8'd0,   8'd0,   1'b0, 1'b0, 1'b1);  // half scale reads entry 0
    queue_pixel(8'd255, 8'd0,   1'b0, 1'b1, 1'b0);  // sub black beats transparency
    queue_pixel(8'd255, 8'd255, 1'b1, 1'b0, 1'b0);  // main black
    queue_pixel(8'd255, 8'd255, 1'b1, 1'b1, 1'b1);  // both black
    queue_pixel(8'd2,   8'd3,   1'b0, 1'b0, 1'b0);
    queue_pixel(8'd4,   8'd5,   1'b0, 1'b0, 1'b1);
    queue_pixel(8'd254, 8'd255, 1'b0, 1'b0, 1'b1);
    queue_pixel(8'd1,   8'd0,   1'b1, 1'b0, 1'b0);  // main black, fixed sub
    // Read straight after a write to the same entry.
    queue_write(8'd6, 15'h1234);
    queue_pixel(8'd6,   8'd6,   1'b0, 1'b0, 1'b0);
    queue_write(8'd0, 15'h0421);
    queue_pixel(8'd0,   8'd0,   1'b0, 1'b0, 1'b1);
    queue_pixel(8'd0,   8'd0,   1'b0, 1'b0, 1'b0);
  endtask

  // Mostly pixels over written entries, a quarter palette writes anywhere.
  task automatic queue_random(int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 25) begin
        queue_write(INDEX_W'($urandom), COLOR_W'($urandom));
      end else begin
        queue_pixel(any_written(),
                    ($urandom_range(0, 4) == 0) ? INDEX_W'(0) : any_written(),
                    $urandom_range(0, 99) < 15,
                    $urandom_range(0, 99) < 15,
                    1'($urandom));
      end
    end
  endtask

  // Wait until every word is taken and every pixel has come back, then let
  // the pipe settle so a trailing palette write has landed.
  task automatic drain();
    while (pending_words.size() != 0 || s_tvalid || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [WORD_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    // The block is idle here, so the shadow registers may move at once.
    case (idx)
      REG_BRIGHTNESS: level_reg = value[LEVEL_W-1:0];
      REG_SUBTRACT:   sub_reg   = value[0];
      REG_FIXED:      fixed_reg = value;
      REG_RED_POS:    red_reg   = value[POS_W-1:0];
      REG_GREEN_POS:  green_reg = value[POS_W-1:0];
      REG_BLUE_POS:   blue_reg  = value[POS_W-1:0];
      default: ;
    endcase
  endtask

  // Program one register setting per phase; upper data bits carry noise so
  // that truncation to the register width is exercised too.
  task automatic program_phase(int unsigned phase);
    logic [LEVEL_W-1:0] lvl;
    logic               sub;
    logic [WORD_W-1:0]  fix;
    logic [POS_W-1:0]   rp;
    logic [POS_W-1:0]   gp;
    logic [POS_W-1:0]   bp;
    rp = POS_W'($urandom_range(0, 24));
    gp = POS_W'($urandom_range(0, 24));
    bp = POS_W'($urandom_range(0, 24));
    fix = $urandom;
    case (phase)
      1: begin
        lvl = 4'd15; sub = 1'b1; fix = '1; rp = 5'd0;  gp = 5'd8;  bp = 5'd16;
      end
      2: begin
        lvl = 4'd0;  sub = 1'b0; fix = '1; rp = 5'd24; gp = 5'd16; bp = 5'd8;
      end
      3: begin
        lvl = 4'd1;  sub = 1'b1;           rp = 5'd24; gp = 5'd0;  bp = 5'd16;
      end
      4: begin
        lvl = 4'd14; sub = 1'b0;           // unaligned random positions
      end
      5: begin
        lvl = 4'd7;  sub = 1'b1; fix = '0;
      end
      6: begin
        lvl = LEVEL_W'($urandom); sub = 1'($urandom);
        rp = RED_POS_RST; gp = GREEN_POS_RST; bp = BLUE_POS_RST;
      end
      default: begin
        lvl = 4'd15; sub = 1'b0;
        rp = POS_W'(8 * $urandom_range(0, 3));
        gp = POS_W'(8 * $urandom_range(0, 3));
        bp = POS_W'(8 * $urandom_range(0, 3));
      end
    endcase
    write_reg(REG_BRIGHTNESS, ($urandom & ~32'hF)  | WORD_W'(lvl));
    write_reg(REG_SUBTRACT,   ($urandom & ~32'h1)  | WORD_W'(sub));
    write_reg(REG_FIXED,      fix);
    write_reg(REG_RED_POS,    ($urandom & ~32'h1F) | WORD_W'(rp));
    write_reg(REG_GREEN_POS,  ($urandom & ~32'h1F) | WORD_W'(gp));
    write_reg(REG_BLUE_POS,   ($urandom & ~32'h1F) | WORD_W'(bp));
    if (phase == 4 || phase == 5) begin
      write_reg(REG_SPARE_A, $urandom);
      write_reg(REG_SPARE_B, $urandom);
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings first: directed words, then a random run.
    @(negedge clk);
    queue_directed();
    queue_random(90);
    drain();

    for (int unsigned phase = 1; phase < PHASES; phase++) begin
      program_phase(phase);
      @(negedge clk);
      quiet = (phase == 6);
      queue_random(123);
      drain();
    end

    if (expected_pixels.size() != 0) begin
      $error("pixel_out: %0d expected words never arrived", expected_pixels.size());
      failures++;
    end
    if (failures == 0) begin
      $display("** palette_color_math_blend_unit: PASSED **");
    end else begin
      $display("** palette_color_math_blend_unit: FAILED **");
    end
    $finish;
  end

endmodule
